/* rtl/core/crpt_pkg.sv */
// Shared types and constants for the Catmull-Rom point and tangent unit.
// No dependencies; imported by the front, queue, back and top level.
package crpt_pkg;

   // Command codes carried on the request channel
   localparam logic CMD_PUSH = 1'b0;
   localparam logic CMD_EVAL = 1'b1;

   // Job queue between the front and the back
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_BITS = 1;
   localparam int QUEUE_CNT_BITS = 2;

   // Queue status seen by both sides
   typedef struct packed {
      logic full;
      logic nonempty;
   } q_flags_type;

endpackage

/* rtl/core/crpt_front.sv */
// Front end: holds the control-point window and the mode register, and turns
// each evaluate beat into a job for the queue. Depends on crpt_pkg.
module crpt_front #(
   parameter int COORD_BITS = 24,
   parameter int PARAM_BITS = 16,
   parameter int JOB_BITS   = 12 * 24 + 16 + 1
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_wr_en,
   input  logic                         csr_wr_data,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic                         req_command,
   input  logic signed [COORD_BITS-1:0] req_point_x,
   input  logic signed [COORD_BITS-1:0] req_point_y,
   input  logic signed [COORD_BITS-1:0] req_point_z,
   input  logic        [PARAM_BITS-1:0] req_param_t,
   input  crpt_pkg::q_flags_type        q_flags,
   output logic                         q_push,
   output logic        [JOB_BITS-1:0]   q_job
);
   import crpt_pkg::*;

   logic signed [COORD_BITS-1:0] window_ff [4][3];
   logic signed [COORD_BITS-1:0] window_in [4][3];
   logic                         mode_ff;
   logic                         mode_in;
   logic                         accept;

   assign req_ready = !q_flags.full;
   assign accept    = req_valid && req_ready;

   always_comb begin
      mode_in   = csr_wr_en ? csr_wr_data : mode_ff;
      window_in = window_ff;
      q_push    = 1'b0;
      if (accept) begin
         case (req_command)
            CMD_PUSH: begin
               // drop the oldest point, shift the new one in at the newest end
               for (int i = 0; i < 3; i++) begin
                  window_in[i] = window_ff[i+1];
               end
               window_in[3][0] = req_point_x;
               window_in[3][1] = req_point_y;
               window_in[3][2] = req_point_z;
            end
            CMD_EVAL: q_push = 1'b1;
            default:  q_push = 1'b0;
         endcase
      end
   end

   // job: window snapshot, then t, then mode on top
   always_comb begin
      q_job = '0;
      for (int p = 0; p < 4; p++) begin
         for (int a = 0; a < 3; a++) begin
            q_job[(p*3+a)*COORD_BITS +: COORD_BITS] = window_ff[p][a];
         end
      end
      q_job[12*COORD_BITS +: PARAM_BITS] = req_param_t;
      q_job[JOB_BITS-1]                  = mode_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b1;
         for (int p = 0; p < 4; p++) begin
            for (int a = 0; a < 3; a++) begin
               window_ff[p][a] <= '0;
            end
         end
      end else begin
         mode_ff   <= mode_in;
         window_ff <= window_in;
      end
   end

endmodule

/* rtl/core/crpt_queue.sv */
// Two-entry job queue that decouples the front end from the evaluator.
// Depends on crpt_pkg for depth and status type.
module crpt_queue #(
   parameter int WIDTH = 305
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  logic [WIDTH-1:0]      push_data,
   input  logic                  pop,
   output logic [WIDTH-1:0]      pop_data,
   output crpt_pkg::q_flags_type flags
);
   import crpt_pkg::*;

   logic [WIDTH-1:0]          entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0] wr_ptr_ff;
   logic [QUEUE_PTR_BITS-1:0] wr_ptr_in;
   logic [QUEUE_PTR_BITS-1:0] rd_ptr_ff;
   logic [QUEUE_PTR_BITS-1:0] rd_ptr_in;
   logic [QUEUE_CNT_BITS-1:0] count_ff;
   logic [QUEUE_CNT_BITS-1:0] count_in;
   logic                      do_push;
   logic                      do_pop;

   assign flags.full     = (count_ff == QUEUE_CNT_BITS'(QUEUE_DEPTH));
   assign flags.nonempty = (count_ff != '0);
   assign do_push        = push && !flags.full;
   assign do_pop         = pop && flags.nonempty;
   assign pop_data       = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

/* rtl/core/crpt_back.sv */
// Evaluator: three axis lanes, each with a position and a tangent multiplier,
// stepped through Horner's scheme by a small sequencer. Depends on crpt_pkg.
module crpt_back #(
   parameter int COORD_BITS = 24,
   parameter int PARAM_BITS = 16,
   parameter int JOB_BITS   = 12 * 24 + 16 + 1
) (
   input  logic                  clock,
   input  logic                  reset,
   input  crpt_pkg::q_flags_type q_flags,
   input  logic [JOB_BITS-1:0]   q_job,
   output logic                  q_pop,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic signed [31:0]    rsp_pos_x,
   output logic signed [31:0]    rsp_pos_y,
   output logic signed [31:0]    rsp_pos_z,
   output logic signed [31:0]    rsp_tan_x,
   output logic signed [31:0]    rsp_tan_y,
   output logic signed [31:0]    rsp_tan_z
);
   import crpt_pkg::*;

   localparam int W  = COORD_BITS + 8;
   localparam int PW = W + PARAM_BITS + 1;
   localparam int SW = (W + 1 > 33) ? W + 1 : 33;
   localparam logic signed [PW-1:0] HALF_LSB =
      {{(W + 1){1'b0}}, 1'b1, {(PARAM_BITS - 1){1'b0}}};
   localparam logic signed [SW-1:0] SAT_MAX = {{(SW - 31){1'b0}}, {31{1'b1}}};
   localparam logic signed [SW-1:0] SAT_MIN = {{(SW - 31){1'b1}}, {31{1'b0}}};
   localparam logic [1:0] LAST_STEP = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_MUL  = 4'b0010,
      ST_ADD  = 4'b0100,
      ST_DONE = 4'b1000
   } state_type;

   state_type                 state_ff, state_in;
   logic [1:0]                step_ff, step_in;
   logic                      mode_ff, mode_in;
   logic [PARAM_BITS-1:0]     t_ff, t_in;
   logic signed [W-1:0]       accp_ff [3];
   logic signed [W-1:0]       accp_in [3];
   logic signed [W-1:0]       acct_ff [3];
   logic signed [W-1:0]       acct_in [3];
   logic signed [W-1:0]       b_ff [3];
   logic signed [W-1:0]       b_in [3];
   logic signed [W-1:0]       c_ff [3];
   logic signed [W-1:0]       c_in [3];
   logic signed [W-1:0]       p1_ff [3];
   logic signed [W-1:0]       p1_in [3];
   logic signed [PW-1:0]      prodp_ff [3];
   logic signed [PW-1:0]      prodp_in [3];
   logic signed [PW-1:0]      prodt_ff [3];
   logic signed [PW-1:0]      prodt_in [3];
   logic signed [31:0]        pos_ff [3];
   logic signed [31:0]        pos_in [3];
   logic signed [31:0]        tan_ff [3];
   logic signed [31:0]        tan_in [3];
   logic                      rsp_valid_ff, rsp_valid_in;

   logic signed [W-1:0]       pt [4][3];
   logic signed [W-1:0]       d_new [3];
   logic signed [W-1:0]       c_new [3];
   logic signed [W-1:0]       addp [3];
   logic signed [W-1:0]       addt [3];
   logic signed [PARAM_BITS:0] t_mul;

   function automatic logic signed [W-1:0] round_q(input logic signed [PW-1:0] v);
      logic signed [PW-1:0] s;
      s = (v + HALF_LSB) >>> PARAM_BITS;
      return s[W-1:0];
   endfunction

   function automatic logic signed [31:0] sat_half(input logic signed [W-1:0] v);
      logic signed [W:0]    h;
      logic signed [SW-1:0] e;
      h = ($signed({v[W-1], v}) + (W+1)'(1)) >>> 1;
      e = SW'(h);
      if (e > SAT_MAX) begin
         return SAT_MAX[31:0];
      end else if (e < SAT_MIN) begin
         return SAT_MIN[31:0];
      end
      return e[31:0];
   endfunction

   function automatic logic signed [31:0] sat_full(input logic signed [W-1:0] v);
      logic signed [SW-1:0] e;
      e = SW'(v);
      if (e > SAT_MAX) begin
         return SAT_MAX[31:0];
      end else if (e < SAT_MIN) begin
         return SAT_MIN[31:0];
      end
      return e[31:0];
   endfunction

   assign t_mul = {1'b0, t_ff};

   // unpack the window snapshot and form the cubic coefficients
   always_comb begin
      for (int p = 0; p < 4; p++) begin
         for (int a = 0; a < 3; a++) begin
            pt[p][a] = W'(signed'(q_job[(p*3+a)*COORD_BITS +: COORD_BITS]));
         end
      end
      for (int a = 0; a < 3; a++) begin
         d_new[a] = pt[3][a] - pt[0][a] + ((pt[1][a] - pt[2][a]) <<< 1)
                  + (pt[1][a] - pt[2][a]);
         c_new[a] = (pt[0][a] <<< 1) - (pt[1][a] <<< 2) - pt[1][a]
                  + (pt[2][a] <<< 2) - pt[3][a];
      end
   end

   // addends for each Horner step
   always_comb begin
      for (int a = 0; a < 3; a++) begin
         case (step_ff)
            2'd0: begin
               addp[a] = mode_ff ? c_ff[a] : p1_ff[a];
               addt[a] = c_ff[a] <<< 1;
            end
            2'd1: begin
               addp[a] = b_ff[a];
               addt[a] = b_ff[a];
            end
            default: begin
               addp[a] = p1_ff[a] <<< 1;
               addt[a] = b_ff[a];
            end
         endcase
      end
   end

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      mode_in      = mode_ff;
      t_in         = t_ff;
      accp_in      = accp_ff;
      acct_in      = acct_ff;
      b_in         = b_ff;
      c_in         = c_ff;
      p1_in        = p1_ff;
      prodp_in     = prodp_ff;
      prodt_in     = prodt_ff;
      pos_in       = pos_ff;
      tan_in       = tan_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      q_pop        = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (q_flags.nonempty) begin
               q_pop   = 1'b1;
               mode_in = q_job[JOB_BITS-1];
               t_in    = q_job[12*COORD_BITS +: PARAM_BITS];
               step_in = 2'd0;
               for (int a = 0; a < 3; a++) begin
                  accp_in[a] = q_job[JOB_BITS-1] ? d_new[a] : pt[2][a] - pt[1][a];
                  acct_in[a] = (d_new[a] <<< 1) + d_new[a];
                  b_in[a]    = pt[2][a] - pt[0][a];
                  c_in[a]    = c_new[a];
                  p1_in[a]   = pt[1][a];
               end
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            for (int a = 0; a < 3; a++) begin
               prodp_in[a] = accp_ff[a] * t_mul;
               prodt_in[a] = acct_ff[a] * t_mul;
            end
            state_in = ST_ADD;
         end
         ST_ADD: begin
            for (int a = 0; a < 3; a++) begin
               accp_in[a] = round_q(prodp_ff[a]) + addp[a];
               if (mode_ff && step_ff != LAST_STEP) begin
                  acct_in[a] = round_q(prodt_ff[a]) + addt[a];
               end
            end
            if (!mode_ff || step_ff == LAST_STEP) begin
               state_in = ST_DONE;
            end else begin
               step_in  = step_ff + 2'd1;
               state_in = ST_MUL;
            end
         end
         ST_DONE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               for (int a = 0; a < 3; a++) begin
                  pos_in[a] = mode_ff ? sat_half(accp_ff[a]) : sat_full(accp_ff[a]);
                  tan_in[a] = mode_ff ? sat_half(acct_ff[a]) : '0;
               end
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      mode_ff  <= mode_in;
      t_ff     <= t_in;
      accp_ff  <= accp_in;
      acct_ff  <= acct_in;
      b_ff     <= b_in;
      c_ff     <= c_in;
      p1_ff    <= p1_in;
      prodp_ff <= prodp_in;
      prodt_ff <= prodt_in;
      pos_ff   <= pos_in;
      tan_ff   <= tan_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_pos_x = pos_ff[0];
   assign rsp_pos_y = pos_ff[1];
   assign rsp_pos_z = pos_ff[2];
   assign rsp_tan_x = tan_ff[0];
   assign rsp_tan_y = tan_ff[1];
   assign rsp_tan_z = tan_ff[2];

endmodule

/* rtl/core/catmull_rom_point_and_tangent_unit.sv */
// Top level of the uniform Catmull-Rom point and tangent unit.
// Depends on crpt_pkg, crpt_front, crpt_queue and crpt_back.
//
// Usage:
//  - Request channel (req_*): valid/ready. A beat with req_command = push
//    shifts (x, y, z) into a four-point window and gives no response; a
//    beat with req_command = evaluate gives one response on the middle span
//    at t = req_param_t (unsigned fraction of one).
//  - Response channel (rsp_*): valid/ready. One beat carries position and
//    tangent, each axis signed, at the same scale as the input points, and saturated to 32 bits.
//    In line mode the position is the straight line between the middle
//    points and the tangent is zero.
//  - csr_wr_en/csr_wr_data write the curve-mode bit (1 = spline, 0 = line);
//    write it only while no evaluation is outstanding.
//  - Push beats update the window register when accepted. An evaluate beat
//    snapshots the window into a two-deep job queue; the evaluator steps three
//    axis lanes (one position and one tangent multiplier each) through three
//    multiply/round-add steps for a spline evaluation and only the first for a
//    line evaluation, then loads the response register before its next job.
//  - Reset clears the window to zero points, empties the queue and sets curve
//    mode. A stalled receiver holds the response register; the evaluator
//    then finishes into its accumulators and waits, and req_ready falls only
//    once the queue is full.
module catmull_rom_point_and_tangent_unit #(
   parameter int COORD_BITS = 24,
   parameter int PARAM_BITS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_wr_en,
   input  logic                         csr_wr_data,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic                         req_command,
   input  logic signed [COORD_BITS-1:0] req_point_x,
   input  logic signed [COORD_BITS-1:0] req_point_y,
   input  logic signed [COORD_BITS-1:0] req_point_z,
   input  logic        [PARAM_BITS-1:0] req_param_t,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic signed [31:0]           rsp_pos_x,
   output logic signed [31:0]           rsp_pos_y,
   output logic signed [31:0]           rsp_pos_z,
   output logic signed [31:0]           rsp_tan_x,
   output logic signed [31:0]           rsp_tan_y,
   output logic signed [31:0]           rsp_tan_z
);
   import crpt_pkg::*;

   // job = window snapshot (12 coordinates), t and the mode bit
   localparam int JOB_BITS = 12 * COORD_BITS + PARAM_BITS + 1;

   q_flags_type         q_flags;
   logic                q_push;
   logic                q_pop;
   logic [JOB_BITS-1:0] q_job_in;
   logic [JOB_BITS-1:0] q_job_out;

   // accept beats, keep the window, issue evaluation jobs
   crpt_front #(
      .COORD_BITS (COORD_BITS),
      .PARAM_BITS (PARAM_BITS),
      .JOB_BITS   (JOB_BITS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_command (req_command),
      .req_point_x (req_point_x),
      .req_point_y (req_point_y),
      .req_point_z (req_point_z),
      .req_param_t (req_param_t),
      .q_flags     (q_flags),
      .q_push      (q_push),
      .q_job       (q_job_in)
   );

   // hold jobs so the front keeps taking beats while the evaluator is busy
   crpt_queue #(
      .WIDTH (JOB_BITS)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_job_in),
      .pop       (q_pop),
      .pop_data  (q_job_out),
      .flags     (q_flags)
   );

   // evaluate and register the response
   crpt_back #(
      .COORD_BITS (COORD_BITS),
      .PARAM_BITS (PARAM_BITS),
      .JOB_BITS   (JOB_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_flags   (q_flags),
      .q_job     (q_job_out),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_pos_x (rsp_pos_x),
      .rsp_pos_y (rsp_pos_y),
      .rsp_pos_z (rsp_pos_z),
      .rsp_tan_x (rsp_tan_x),
      .rsp_tan_y (rsp_tan_y),
      .rsp_tan_z (rsp_tan_z)
   );

endmodule
